// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and codes for the I2C register-access master.
package i2cm_pkg;

   // Request codes carried in req_type
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_WRITE   = 3'd1;
   localparam logic [2:0] REQ_READ    = 3'd2;
   localparam logic [2:0] REQ_RECOVER = 3'd3;
   localparam logic [2:0] REQ_PAYLOAD = 3'd4;

   localparam int unsigned BYTE_BITS = 8;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_SEND_DEV  = 4'd1,
      PH_SEND_REG  = 4'd2,
      PH_WAIT      = 4'd3,
      PH_SEND_DATA = 4'd4,
      PH_RESTART   = 4'd5,
      PH_SEND_DEVR = 4'd6,
      PH_RECV      = 4'd7,
      PH_RECOVER   = 4'd8,
      PH_STOP_OK   = 4'd9,
      PH_STOP_ERR  = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_WRITE   = 2'd1,
      MODE_READ    = 2'd2,
      MODE_RECOVER = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        sda_in;
      logic [7:0]  target_addr;
      logic [7:0]  reg_addr;
      logic [15:0] length;
      logic [7:0]  wr_data;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       rd_last;
      logic       need_data;
      logic       done_res;
      logic       status;
      logic       busy_res;
   } rsp_item_type;

endpackage

// ===== rtl/core/i2cm_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface i2cm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic        sda_in;
   logic [7:0]  target_addr;
   logic [7:0]  reg_addr;
   logic [15:0] length;
   logic [7:0]  wr_data;

   modport source (output valid, req_type, sda_in, target_addr, reg_addr, length, wr_data,
                   input ready);
   modport sink   (input valid, req_type, sda_in, target_addr, reg_addr, length, wr_data,
                   output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic [7:0] rd_data;
   logic       rd_valid;
   logic       rd_last;
   logic       need_data;
   logic       done_res;
   logic       status;
   logic       busy_res;

   modport source (output valid, scl_out, sda_out, rd_data, rd_valid, rd_last, need_data,
                   done_res, status, busy_res,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, rd_data, rd_valid, rd_last, need_data,
                   done_res, status, busy_res,
                   output ready);
endinterface

// ===== rtl/core/i2cm_core.sv =====
// Bus phase sequencer: transaction state and per-item next-state logic.
module i2cm_core
   import i2cm_pkg::*;
#(
   parameter int unsigned RECOVERY_PULSES = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result,
   output phase_type    phase
);

   phase_type   phase_ff, phase_in;
   mode_type    mode_ff, mode_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] byte_cnt_ff, byte_cnt_in;
   logic [15:0] byte_total_ff, byte_total_in;
   logic [7:0]  dev_ff, dev_in;
   logic [7:0]  reg_ff, reg_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   logic [16:0] byte_inc;
   logic        rd_last;
   logic        bits_left;
   logic [7:0]  rd_byte;
   logic        rd_vld;
   logic        done;
   logic        stat;

   assign byte_inc  = {1'b0, byte_cnt_ff} + 17'd1;
   assign bits_left = (bit_cnt_ff < 4'(BYTE_BITS));

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      byte_cnt_in   = byte_cnt_ff;
      byte_total_in = byte_total_ff;
      dev_in        = dev_ff;
      reg_in        = reg_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rd_byte       = 8'd0;
      rd_vld        = 1'b0;
      rd_last       = 1'b0;
      done          = 1'b0;
      stat          = 1'b0;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
               dev_in        = item.target_addr;
               reg_in        = item.reg_addr;
               byte_total_in = item.length;
               byte_cnt_in   = 16'd0;
               bit_cnt_in    = 4'd0;
               shift_in      = {item.target_addr[7:1], 1'b0};
               mode_in       = (item.req_type == REQ_WRITE) ? MODE_WRITE : MODE_READ;
               scl_in        = 1'b1;
               sda_in        = 1'b0;
               phase_in      = PH_SEND_DEV;
            end else if (item.req_type == REQ_RECOVER) begin
               mode_in    = MODE_RECOVER;
               scl_in     = 1'b1;
               sda_in     = 1'b1;
               bit_cnt_in = 4'(RECOVERY_PULSES - 1);
               phase_in   = PH_RECOVER;
            end
         end else if (phase_ff == PH_WAIT) begin
            if (item.req_type == REQ_PAYLOAD) begin
               shift_in   = item.wr_data;
               bit_cnt_in = 4'd0;
               phase_in   = PH_SEND_DATA;
            end
         end else if (item.req_type == REQ_TICK) begin
            unique case (phase_ff)
               PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_DEVR: begin
                  scl_in = 1'b1;
                  if (bits_left) begin
                     sda_in     = shift_ff[7];
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_ff + 4'd1;
                  end else begin
                     // ACK slot: SDA released, sample the device
                     sda_in     = 1'b1;
                     bit_cnt_in = 4'd0;
                     if (item.sda_in) begin
                        phase_in = PH_STOP_ERR;
                     end else begin
                        case (phase_ff)
                           PH_SEND_DEV: begin
                              shift_in = reg_ff;
                              phase_in = PH_SEND_REG;
                           end
                           PH_SEND_REG: begin
                              if (mode_ff == MODE_READ) begin
                                 phase_in = PH_RESTART;
                              end else if (byte_total_ff == 16'd0) begin
                                 phase_in = PH_STOP_OK;
                              end else begin
                                 phase_in = PH_WAIT;
                                 scl_in   = 1'b0;
                              end
                           end
                           PH_SEND_DATA: begin
                              byte_cnt_in = byte_inc[15:0];
                              if (byte_inc[15:0] >= byte_total_ff) begin
                                 phase_in = PH_STOP_OK;
                              end else begin
                                 phase_in = PH_WAIT;
                                 scl_in   = 1'b0;
                              end
                           end
                           default: begin
                              byte_cnt_in = 16'd0;
                              shift_in    = 8'd0;
                              phase_in    = (byte_total_ff == 16'd0) ? PH_STOP_OK : PH_RECV;
                           end
                        endcase
                     end
                  end
               end
               PH_RESTART: begin
                  scl_in     = 1'b1;
                  sda_in     = 1'b0;
                  shift_in   = {dev_ff[7:1], 1'b1};
                  bit_cnt_in = 4'd0;
                  phase_in   = PH_SEND_DEVR;
               end
               PH_RECV: begin
                  scl_in = 1'b1;
                  if (bits_left) begin
                     sda_in     = 1'b1;
                     shift_in   = {shift_ff[6:0], item.sda_in};
                     bit_cnt_in = bit_cnt_ff + 4'd1;
                  end else begin
                     // master ACK, or NACK on the final byte
                     rd_last     = (byte_inc >= {1'b0, byte_total_ff});
                     sda_in      = rd_last;
                     rd_byte     = shift_ff;
                     rd_vld      = 1'b1;
                     shift_in    = 8'd0;
                     bit_cnt_in  = 4'd0;
                     byte_cnt_in = byte_inc[15:0];
                     if (rd_last) begin
                        phase_in = PH_STOP_OK;
                     end
                  end
               end
               PH_RECOVER: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  if (bit_cnt_ff != 4'd0) begin
                     bit_cnt_in = bit_cnt_ff - 4'd1;
                  end else begin
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                     mode_in  = MODE_NONE;
                  end
               end
               PH_STOP_OK, PH_STOP_ERR: begin
                  stat     = (phase_ff == PH_STOP_ERR);
                  done     = 1'b1;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
                  mode_in  = MODE_NONE;
               end
               default: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
                  mode_in  = MODE_NONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         mode_ff       <= MODE_NONE;
         bit_cnt_ff    <= 4'd0;
         shift_ff      <= 8'd0;
         byte_cnt_ff   <= 16'd0;
         byte_total_ff <= 16'd0;
         dev_ff        <= 8'd0;
         reg_ff        <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         byte_cnt_ff   <= byte_cnt_in;
         byte_total_ff <= byte_total_in;
         dev_ff        <= dev_in;
         reg_ff        <= reg_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

   always_comb begin
      result.scl_out   = scl_in;
      result.sda_out   = sda_in;
      result.rd_data   = rd_byte;
      result.rd_valid  = rd_vld;
      result.rd_last   = rd_last;
      result.need_data = (phase_in == PH_WAIT);
      result.done_res  = done;
      result.status    = stat;
      result.busy_res  = (phase_in != PH_IDLE);
   end

   assign phase = phase_ff;

endmodule

// ===== rtl/core/i2c_master_register_access_top.sv =====
// Top level: request register, phase sequencer and response register.
// I2C master for register read/write transactions. A request item moves
// the bus by at most one phase (START, one address or data bit, an ACK slot,
// repeated START, STOP) and returns exactly one response item with the SCL/SDA
// levels for that phase plus read data and status flags. An accepted item is
// held in the request register and is evaluated against the transaction state
// once the response register can take it; its response is then offered from
// the response register, and a new item is taken every cycle while the
// response side keeps up; the phase sequencer's state update sets that rate.
// Write payload bytes are supplied as separate items while need_data is high.
module i2c_master_register_access_top
   import i2cm_pkg::*;
#(
   parameter int unsigned RECOVERY_PULSES = 9
) (
   input logic    clock,
   input logic    reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan
);

   logic         in_vld_ff;
   req_item_type in_item_ff;
   logic         out_vld_ff;
   rsp_item_type out_item_ff;
   logic         advance;
   rsp_item_type core_rsp;
   phase_type    phase;

   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.req_type    <= req_chan.req_type;
         in_item_ff.sda_in      <= req_chan.sda_in;
         in_item_ff.target_addr <= req_chan.target_addr;
         in_item_ff.reg_addr    <= req_chan.reg_addr;
         in_item_ff.length      <= req_chan.length;
         in_item_ff.wr_data     <= req_chan.wr_data;
      end
   end

   i2cm_core #(
      .RECOVERY_PULSES(RECOVERY_PULSES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_rsp),
      .phase  (phase)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.scl_out   = out_item_ff.scl_out;
   assign rsp_chan.sda_out   = out_item_ff.sda_out;
   assign rsp_chan.rd_data   = out_item_ff.rd_data;
   assign rsp_chan.rd_valid  = out_item_ff.rd_valid;
   assign rsp_chan.rd_last   = out_item_ff.rd_last;
   assign rsp_chan.need_data = out_item_ff.need_data;
   assign rsp_chan.done_res  = out_item_ff.done_res;
   assign rsp_chan.status    = out_item_ff.status;
   assign rsp_chan.busy_res  = out_item_ff.busy_res;

   // a finished transaction leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      advance && core_rsp.done_res |=> phase == PH_IDLE)
      else $error("sequencer not idle after done");

   // NACK status only comes with the STOP transfer
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status |-> rsp_chan.done_res && !rsp_chan.busy_res)
      else $error("status without done");

   // a read byte is reported on a clock-high ACK slot while the bus is still owned
   a_rd_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.rd_valid |-> rsp_chan.scl_out && rsp_chan.busy_res)
      else $error("read byte outside ACK slot");

   // waiting for payload holds SCL low
   a_wait_scl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.need_data |-> !rsp_chan.scl_out && rsp_chan.sda_out)
      else $error("payload wait with SCL released");

endmodule
